>>> src/bpr_pkg.sv
// shared types and constants for the bitfield pixel unpacker
package bpr_pkg;

   localparam int unsigned CHANNELS  = 4;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned DIV_STEPS = 32;

   // csr register indexes
   localparam logic [2:0] REG_BPP   = 3'd0;
   localparam logic [2:0] REG_RED   = 3'd1;
   localparam logic [2:0] REG_GREEN = 3'd2;
   localparam logic [2:0] REG_BLUE  = 3'd3;
   localparam logic [2:0] REG_ALPHA = 3'd4;

   // how a channel result is formed at the end of the divider chain
   typedef enum logic [1:0] {
      CH_DIV  = 2'd0,
      CH_ZERO = 2'd1,
      CH_ONES = 2'd2,
      CH_PASS = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] num;
      logic [31:0] dvs;
      logic [31:0] rem;
      logic [7:0]  quo;
      logic [7:0]  raw8;
   } ch_type;

   typedef ch_type [CHANNELS-1:0] chv_type;

   typedef logic [CHANNELS-1:0][31:0] maskv_type;

endpackage

>>> src/bitfield_pixel_to_rgba8.sv
// top level: csr registers, front end, divider cell chain and output register
// stages from req transaction to rsp valid: 3 front stages,
//   32 divider cells one quotient bit each, one output register
// throughput: one pixel per cycle; every stage stalls only when full
// reset: synchronous, clears all valid bits and loads the default masks
module bitfield_pixel_to_rgba8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pixel_bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red, green, blue, alpha
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import bpr_pkg::*;

   logic [2:0]  bpp_ff;
   maskv_type   mask_ff;

   logic    [DIV_STEPS:0] c_valid;
   logic    [DIV_STEPS:0] c_ready;
   chv_type [DIV_STEPS:0] c_ch;

   logic        out_vld_ff, out_vld_in;
   logic [31:0] out_dat_ff, out_dat_in;
   logic        out_adv;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff     <= 3'd3;
         mask_ff[0] <= 32'h00FF0000;
         mask_ff[1] <= 32'h0000FF00;
         mask_ff[2] <= 32'h000000FF;
         mask_ff[3] <= 32'h0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_BPP:   bpp_ff     <= csr_wdata[2:0];
            REG_RED:   mask_ff[0] <= csr_wdata;
            REG_GREEN: mask_ff[1] <= csr_wdata;
            REG_BLUE:  mask_ff[2] <= csr_wdata;
            REG_ALPHA: mask_ff[3] <= csr_wdata;
            default:   ;
         endcase
      end
   end

   bpr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .bpp       (bpp_ff),
      .masks     (mask_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_word   (req_tdata),
      .out_valid (c_valid[0]),
      .out_ready (c_ready[0]),
      .out_ch    (c_ch[0])
   );

   // divider chain, most significant quotient bit first
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      bpr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_ch     (c_ch[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_ch    (c_ch[i+1])
      );
   end

   // result select and output register
   assign out_adv             = !out_vld_ff || rsp_tready;
   assign c_ready[DIV_STEPS]  = out_adv;
   assign out_vld_in          = out_adv ? c_valid[DIV_STEPS] : out_vld_ff;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         case (c_ch[DIV_STEPS][c].kind)
            CH_DIV:  out_dat_in[c*8 +: 8] = c_ch[DIV_STEPS][c].quo;
            CH_ZERO: out_dat_in[c*8 +: 8] = 8'h00;
            CH_ONES: out_dat_in[c*8 +: 8] = 8'hFF;
            CH_PASS: out_dat_in[c*8 +: 8] = c_ch[DIV_STEPS][c].raw8;
            default: out_dat_in[c*8 +: 8] = 8'h00;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         out_dat_ff <= out_dat_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_dat_ff;

   // nothing leaves the chain straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !c_valid[DIV_STEPS])
      else $error("result valid right after reset");

   // remainder of a finished division stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      c_valid[DIV_STEPS] && c_ch[DIV_STEPS][0].kind == CH_DIV
      |-> c_ch[DIV_STEPS][0].rem < c_ch[DIV_STEPS][0].dvs)
      else $error("red remainder not below divisor");

   // a full chain end with a stalled output must hold back the last cell
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !c_ready[DIV_STEPS])
      else $error("last cell released into a stalled output");

   // an empty first front stage always takes a pixel
   a_front_ready: assert property (@(posedge clock) disable iff (reset)
      !u_front.vld_ff[0] |-> req_tready)
      else $error("front end refused a pixel");

endmodule

>>> src/bpr_front.sv
// front end: size cut, field decode, shift down and dividend forming
module bpr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        bpp,
   input  bpr_pkg::maskv_type masks,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output bpr_pkg::chv_type  out_ch
);
   import bpr_pkg::*;

   logic [2:0] vld_ff, vld_in;
   logic [2:0] adv;

   // stage one: masked word, lowest run and its shift
   logic [CHANNELS-1:0][31:0] mword_ff, mword_in;
   logic [CHANNELS-1:0][31:0] run_ff, run_in;
   logic [CHANNELS-1:0][4:0]  sh_ff, sh_in;
   // stage two: raw field and max
   logic [CHANNELS-1:0][31:0] raw_ff, raw_in;
   logic [CHANNELS-1:0][31:0] top_ff, top_in;
   kind_type [CHANNELS-1:0]   kind_ff, kind_in;
   // stage three: dividend
   chv_type ch_ff, ch_in;

   logic [31:0] word_cut;

   // stall chain, a stage moves when empty or when its successor takes it
   assign adv[2]    = !vld_ff[2] || out_ready;
   assign adv[1]    = !vld_ff[1] || adv[2];
   assign adv[0]    = !vld_ff[0] || adv[1];
   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_ch    = ch_ff;

   always_comb begin
      vld_in[0] = adv[0] ? in_valid  : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
   end

   // cut to stored pixel size
   always_comb begin
      case (bpp) inside
         [3'd0:3'd2]: word_cut = {16'h0, in_word[15:0]};
         3'd3:        word_cut = {8'h0, in_word[23:0]};
         default:     word_cut = in_word;
      endcase
   end

   // lowest run of ones and trailing zero count
   always_comb begin
      logic [31:0] low;
      for (int c = 0; c < CHANNELS; c++) begin
         low         = masks[c] & (~masks[c] + 32'd1);
         run_in[c]   = masks[c] & ~(masks[c] + low);
         mword_in[c] = word_cut & masks[c];
         sh_in[c]    = 5'd0;
         for (int j = 0; j < WORD_W; j++) begin
            if (low[j]) sh_in[c] = sh_in[c] | j[4:0];
         end
      end
   end

   // shift field and max down
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         raw_in[c] = mword_ff[c] >> sh_ff[c];
         top_in[c] = run_ff[c] >> sh_ff[c];
         if (top_in[c] == 32'h0)
            kind_in[c] = (c == CHANNELS - 1) ? CH_ONES : CH_ZERO;
         else if (top_in[c] == 32'hFF)
            kind_in[c] = CH_PASS;
         else
            kind_in[c] = CH_DIV;
      end
   end

   // raw*255 + max/2, wrapped to 32 bits
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         ch_in[c].kind = kind_ff[c];
         ch_in[c].num  = (raw_ff[c] << 8) - raw_ff[c] + (top_ff[c] >> 1);
         ch_in[c].dvs  = top_ff[c];
         ch_in[c].rem  = 32'h0;
         ch_in[c].quo  = 8'h0;
         ch_in[c].raw8 = raw_ff[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mword_ff <= mword_in;
         run_ff   <= run_in;
         sh_ff    <= sh_in;
      end
      if (adv[1]) begin
         raw_ff  <= raw_in;
         top_ff  <= top_in;
         kind_ff <= kind_in;
      end
      if (adv[2]) begin
         ch_ff <= ch_in;
      end
   end

endmodule

>>> src/bpr_div_cell.sv
// one restoring divider step for all four channels
module bpr_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bpr_pkg::chv_type in_ch,
   output logic             out_valid,
   input  logic             out_ready,
   output bpr_pkg::chv_type out_ch
);
   import bpr_pkg::*;

   logic    vld_ff, vld_in;
   chv_type ch_ff, ch_in;
   logic    adv;

   assign adv       = !vld_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff;
   assign out_ch    = ch_ff;
   assign vld_in    = adv ? in_valid : vld_ff;

   // bring down the next dividend bit, subtract when it fits
   always_comb begin
      logic [32:0] part;
      logic [32:0] diff;
      for (int c = 0; c < CHANNELS; c++) begin
         part         = {in_ch[c].rem, in_ch[c].num[31]};
         diff         = part - {1'b0, in_ch[c].dvs};
         ch_in[c]     = in_ch[c];
         ch_in[c].num = {in_ch[c].num[30:0], 1'b0};
         if (!diff[32]) begin
            ch_in[c].rem = diff[31:0];
            ch_in[c].quo = {in_ch[c].quo[6:0], 1'b1};
         end else begin
            ch_in[c].rem = part[31:0];
            ch_in[c].quo = {in_ch[c].quo[6:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ch_ff <= ch_in;
      end
   end

endmodule

>>> tb/bitfield_pixel_to_rgba8_tb.sv
// testbench for the bitfield pixel unpacker: directed and randomised stream traffic against a local predictor
`timescale 1ns / 1ps

module bitfield_pixel_to_rgba8_tb;
   import bpr_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES   = 60;
   localparam int unsigned HOLD_CYCLES    = 200;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;

   // predictor copy of the csr registers
   logic [2:0]  bpp_q;
   maskv_type   masks_q;

   logic [31:0] pixel_queue[$];
   logic [31:0] rgba_queue[$];
   int unsigned mismatches = 0;
   int unsigned idle_cycles;
   int unsigned req_wait;
   int unsigned rsp_wait;
   int unsigned hold_left;
   bit          hold_request;

   bitfield_pixel_to_rgba8 dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // rescale one masked field to eight bits
   function automatic logic [7:0] rescale_field(logic [31:0] word, logic [31:0] mask);
      logic [31:0] m;
      logic [31:0] raw;
      logic [31:0] top;
      logic [31:0] num;
      int unsigned sh;
      int unsigned wd;
      m = mask;
      sh = 0;
      wd = 0;
      if (mask == 32'd0) return 8'd0;
      while (m[0] == 1'b0) begin
         m = m >> 1;
         sh++;
      end
      while (m[0] == 1'b1 && wd < 32) begin
         m = m >> 1;
         wd++;
      end
      raw = (word & mask) >> sh;
      top = (wd >= 32) ? 32'hFFFF_FFFF : ((32'd1 << wd) - 32'd1);
      if (wd == 8) return raw[7:0];
      num = raw * 32'd255 + top / 32'd2;
      return 8'(num / top);
   endfunction

   // expected packed rgba for one pixel word
   function automatic logic [31:0] predict_rgba(logic [31:0] pixel);
      logic [31:0] word;
      logic [7:0]  a;
      word = pixel;
      if (bpp_q <= 3'd2) word = word & 32'h0000_FFFF;
      else if (bpp_q == 3'd3) word = word & 32'h00FF_FFFF;
      a = (masks_q[3] != 32'd0) ? rescale_field(word, masks_q[3]) : 8'd255;
      return {a, rescale_field(word, masks_q[2]), rescale_field(word, masks_q[1]),
              rescale_field(word, masks_q[0])};
   endfunction

   task automatic write_csr(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (addr)
         REG_BPP:   bpp_q      = data[2:0];
         REG_RED:   masks_q[0] = data;
         REG_GREEN: masks_q[1] = data;
         REG_BLUE:  masks_q[2] = data;
         REG_ALPHA: masks_q[3] = data;
         default: ;
      endcase
   endtask

   task automatic set_format(logic [2:0] bpp, logic [31:0] r, logic [31:0] g,
                             logic [31:0] b, logic [31:0] a);
      write_csr(REG_BPP, {29'd0, bpp});
      write_csr(REG_RED, r);
      write_csr(REG_GREEN, g);
      write_csr(REG_BLUE, b);
      write_csr(REG_ALPHA, a);
   endtask

   // wait for every pending transaction to come back, then let the pipe empty
   task automatic drain_pipe();
      while (pixel_queue.size() != 0 || rgba_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_mask();
      logic [31:0] m;
      int unsigned lo;
      int unsigned w;
      case ($urandom_range(0, 5))
         0: m = 32'd0;
         1: m = $urandom();
         2: m = 32'hFFFF_FFFF;
         default: begin
            lo = $urandom_range(0, 31);
            w  = $urandom_range(1, 32 - lo);
            m  = ((w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1)) << lo;
         end
      endcase
      return m;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 32'd0;
         req_wait   <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold offer
      end else begin
         if (req_tvalid && req_tready) void'(pixel_queue.pop_front());
         if (req_wait != 0) begin
            req_wait   <= req_wait - 1;
            req_tvalid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pixel_queue[0];
            rgba_queue.push_back(predict_rgba(pixel_queue[0]));
            req_wait   <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 14) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         rsp_wait    <= 0;
         hold_left   <= 0;
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (rgba_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rgba transaction %h", rsp_tdata);
            end else begin
               if (rsp_tdata !== rgba_queue[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rgba mismatch: expected %h got %h", rgba_queue[0], rsp_tdata);
               end
               void'(rgba_queue.pop_front());
            end
         end
         if (hold_request && hold_left == 0) begin
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 1) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_wait != 0) begin
            hold_left  <= 0;
            rsp_wait   <= rsp_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            hold_left  <= 0;
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready && $urandom_range(0, 3) == 0)
               rsp_wait <= $urandom_range(0, 14);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [2:0] bpp;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_addr     = REG_BPP;
      csr_wdata    = 32'd0;
      hold_request = 1'b0;
      bpp_q        = 3'd3;
      masks_q      = {32'd0, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset format, field extremes
      pixel_queue.push_back(32'h0000_0000);
      pixel_queue.push_back(32'hFFFF_FFFF);
      pixel_queue.push_back(32'h00A5_5A3C);
      drain_pipe();
      // 16-bit 555 with a one-bit alpha
      set_format(3'd2, 32'h7C00, 32'h03E0, 32'h001F, 32'h8000);
      pixel_queue.push_back(32'hFFFF_FFFF);
      pixel_queue.push_back(32'h1234_7FFF);
      pixel_queue.push_back(32'h0000_8421);
      drain_pipe();
      // stored size out of range, low side
      set_format(3'd0, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h0000_000F, 32'h0);
      pixel_queue.push_back(32'hFFFF_FFFF);
      pixel_queue.push_back(32'h8000_0001);
      drain_pipe();
      set_format(3'd1, 32'h0000_F000, 32'h0, 32'h0000_0001, 32'h0000_0F00);
      pixel_queue.push_back(32'h0000_FFFF);
      pixel_queue.push_back(32'h0000_5A5A);
      drain_pipe();
      // full word masks, split runs, out of range on the high side
      set_format(3'd7, 32'hFFFF_FFFF, 32'h8000_0000, 32'hF0F0_0000, 32'h0000_0F0F);
      pixel_queue.push_back(32'hFFFF_FFFF);
      pixel_queue.push_back(32'h8765_4321);
      pixel_queue.push_back(32'h0000_0001);
      drain_pipe();
      set_format(3'd5, 32'hFF00_0000, 32'h0000_0003, 32'h00FF_FFFF, 32'h5555_5555);
      pixel_queue.push_back(32'hFFFF_FFFF);
      pixel_queue.push_back(32'hAAAA_AAAA);
      drain_pipe();
      set_format(3'd4, 32'h0000_0FF0, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hFF00_0000);
      pixel_queue.push_back(32'hFFFF_FFFF);
      pixel_queue.push_back(32'h7FFF_FFFE);
      drain_pipe();

      // random phases, one with a long receiver hold-off
      for (int phase = 0; phase < 9; phase++) begin
         bpp = (phase == 0) ? 3'd6 : 3'($urandom_range(0, 7));
         set_format(bpp, random_mask(), random_mask(), random_mask(), random_mask());
         for (int i = 0; i < 150; i++) pixel_queue.push_back($urandom());
         if (phase == 4) begin
            @(posedge clock);
            hold_request <= 1'b1;
            @(posedge clock);
            hold_request <= 1'b0;
         end
         drain_pipe();
      end

      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> bitfield_pixel_to_rgba8.f
src/bpr_pkg.sv
src/bpr_front.sv
src/bpr_div_cell.sv
src/bitfield_pixel_to_rgba8.sv
tb/bitfield_pixel_to_rgba8_tb.sv
